// File: rtl/oplc_pkg.sv
// Package for the slab page layout calculator: constants, status codes and
// the context record that travels alongside the divider pipelines.
// No dependencies.
package oplc_pkg;

	localparam int unsigned HEADER_BYTES = 16;
	localparam logic [31:0] PAGE_LIMIT   = 32'h1FFF_FFFF;
	localparam logic [31:0] MIN_OBJECTS  = 32'd10;

	// Divider geometry: 32-bit dividend, 33-bit divisor, one quotient bit a stage
	localparam int unsigned DIV_STAGES = 32;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ALIGN  = 3'd1,
		ST_PAGE_BIG   = 3'd2,
		ST_PAGE_SMALL = 3'd3,
		ST_ZERO_OBJ   = 3'd4
	} status_t;

	// Per-item context carried through the pipeline
	typedef struct packed {
		status_t      status;
		logic [29:0]  size;    // aligned object size
		logic [2:0]   amask;   // alignment minus one
		logic [31:0]  page;
		logic [28:0]  count;
		logic [26:0]  bitmap;
		logic [26:0]  offset;
		logic         redo;    // offset moved by alignment, count again
	} ctx_t;

endpackage

// File: rtl/object_page_layout_calc_top.sv
// Slab page layout calculator, top level.
// Depends on oplc_pkg and oplc_div.
//
// Usage: one item on the input channel (object_bytes, page_bytes, alignment)
// gives one result item (status and the four layout fields) on the output
// channel. Both channels use valid/ready.
// Stages: an input check stage, a 32-stage divider for the first slot
// count, a stage for bitmap and offset, a stage for the bytes left after
// the offset, a second 32-stage divider for the recount after alignment,
// and the output register. Throughput is one item per cycle while results
// are taken; the two bit-per-stage dividers set the depth, not the rate.
// The whole pipeline moves on one enable: when the output holds a result
// that is not taken, every stage holds and in_ready drops, so nothing is
// lost or repeated. Reset clears all valid bits; the block then takes an
// item in the first cycle after reset.
module object_page_layout_calc_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [28:0] object_bytes,
	input  logic [31:0] page_bytes,
	input  logic [7:0]  alignment,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [29:0] aligned_object_bytes,
	output logic [28:0] objects_per_page,
	output logic [26:0] bitmap_bytes,
	output logic [26:0] object_area_offset
);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: checks, rounded size, first dividend and divisor
	logic            vld_s1;
	oplc_pkg::ctx_t  ctx_s1;
	logic [31:0]     dvd_s1;
	logic [32:0]     dvs_s1;

	oplc_pkg::ctx_t  c1;
	logic            align_ok;
	logic [2:0]      am;
	logic [29:0]     size_c;
	logic [31:0]     page_net;

	always_comb begin
		align_ok = (alignment == 8'd1) || (alignment == 8'd2) ||
		           (alignment == 8'd4) || (alignment == 8'd8);
		am       = alignment[2:0] - 3'd1;
		size_c   = ({1'b0, object_bytes} + {27'd0, am}) & ~{27'd0, am};
		page_net = page_bytes - 32'(oplc_pkg::HEADER_BYTES);
		c1         = '0;
		c1.amask   = am;
		c1.size    = size_c;
		c1.page    = page_bytes;
		priority if (!align_ok) begin
			c1.status = oplc_pkg::ST_BAD_ALIGN;
			c1.size   = '0;
		end else if (page_bytes > oplc_pkg::PAGE_LIMIT) begin
			c1.status = oplc_pkg::ST_PAGE_BIG;
		end else if (size_c == '0) begin
			c1.status = oplc_pkg::ST_ZERO_OBJ;
		end else if (page_bytes < 32'(oplc_pkg::HEADER_BYTES)) begin
			c1.status = oplc_pkg::ST_PAGE_SMALL;
		end else begin
			c1.status = oplc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= c1;
			dvd_s1 <= {page_net[28:0], 3'b000};
			dvs_s1 <= {size_c, 3'b000} + 33'd1;
		end
	end

	// First division: slots counting one bitmap bit each
	logic            d1_vld;
	logic [31:0]     d1_q;
	oplc_pkg::ctx_t  d1_ctx;

	oplc_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.dividend (dvd_s1),
		.divisor  (dvs_s1),
		.in_ctx   (ctx_s1),
		.out_vld  (d1_vld),
		.quotient (d1_q),
		.out_ctx  (d1_ctx)
	);

	// Stage 2: minimum check, bitmap and aligned offset
	logic            vld_s2;
	oplc_pkg::ctx_t  ctx_s2;
	oplc_pkg::ctx_t  c2;
	logic [29:0]     bm_sum;
	logic [27:0]     off_raw;
	logic [27:0]     off_up;

	always_comb begin
		c2      = d1_ctx;
		bm_sum  = {1'b0, d1_q[28:0]} + 30'd7;
		off_raw = 28'(oplc_pkg::HEADER_BYTES) + {1'b0, bm_sum[29:3]};
		off_up  = (off_raw + {25'd0, d1_ctx.amask}) & ~{25'd0, d1_ctx.amask};
		if (d1_ctx.status == oplc_pkg::ST_OK) begin
			if (d1_q < oplc_pkg::MIN_OBJECTS) begin
				c2.status = oplc_pkg::ST_PAGE_SMALL;
			end else begin
				c2.count  = d1_q[28:0];
				c2.bitmap = bm_sum[29:3];
				c2.offset = off_up[26:0];
				c2.redo   = (off_raw[2:0] & d1_ctx.amask) != 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= c2;
		end
	end

	// Stage 3: bytes left after the object area offset, saturating
	logic            vld_s3;
	oplc_pkg::ctx_t  ctx_s3;
	logic [31:0]     dvd_s3;
	logic [31:0]     off_ext;

	assign off_ext = {5'd0, ctx_s2.offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_s2;
			dvd_s3 <= (ctx_s2.page > off_ext) ? ctx_s2.page - off_ext : '0;
		end
	end

	// Second division: recount after the offset moved
	logic            d2_vld;
	logic [31:0]     d2_q;
	oplc_pkg::ctx_t  d2_ctx;

	oplc_div u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.dividend (dvd_s3),
		.divisor  ({3'd0, ctx_s3.size}),
		.in_ctx   (ctx_s3),
		.out_vld  (d2_vld),
		.quotient (d2_q),
		.out_ctx  (d2_ctx)
	);

	// Output register: pick the recount where needed, zero on error
	logic            vld_s4;
	logic [2:0]      st_s4;
	logic [29:0]     size_s4;
	logic [28:0]     cnt_s4;
	logic [26:0]     bm_s4;
	logic [26:0]     off_s4;
	logic [29:0]     bm2_sum;
	logic            ok;

	assign bm2_sum = {1'b0, d2_q[28:0]} + 30'd7;
	assign ok      = (d2_ctx.status == oplc_pkg::ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4   <= d2_ctx.status;
			size_s4 <= d2_ctx.size;
			if (!ok) begin
				cnt_s4 <= '0;
				bm_s4  <= '0;
				off_s4 <= '0;
			end else if (d2_ctx.redo) begin
				cnt_s4 <= d2_q[28:0];
				bm_s4  <= bm2_sum[29:3];
				off_s4 <= d2_ctx.offset;
			end else begin
				cnt_s4 <= d2_ctx.count;
				bm_s4  <= d2_ctx.bitmap;
				off_s4 <= d2_ctx.offset;
			end
		end
	end

	assign out_valid            = vld_s4;
	assign status               = st_s4;
	assign aligned_object_bytes = size_s4;
	assign objects_per_page     = cnt_s4;
	assign bitmap_bytes         = bm_s4;
	assign object_area_offset   = off_s4;

endmodule

// File: rtl/oplc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the item
// context carried beside the data. Depends on oplc_pkg.
module oplc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [31:0]        dividend,
	input  logic [32:0]        divisor,
	input  oplc_pkg::ctx_t     in_ctx,
	output logic               out_vld,
	output logic [31:0]        quotient,
	output oplc_pkg::ctx_t     out_ctx
);

	localparam int unsigned N = oplc_pkg::DIV_STAGES;

	logic                 vld_s [N+1];
	logic [32:0]          rem_s [N+1];
	logic [31:0]          dq_s  [N+1];
	logic [32:0]          dv_s  [N+1];
	oplc_pkg::ctx_t       ctx_s [N+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = '0;
	assign dq_s[0]  = dividend;
	assign dv_s[0]  = divisor;
	assign ctx_s[0] = in_ctx;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [33:0] trial;
		logic [33:0] diff;
		logic        take;

		// shift in the next dividend bit and try a subtract
		always_comb begin
			trial = {rem_s[i], dq_s[i][31]};
			diff  = trial - {1'b0, dv_s[i]};
			take  = (trial >= {1'b0, dv_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? diff[32:0] : trial[32:0];
				dq_s[i+1]  <= {dq_s[i][30:0], take};
				dv_s[i+1]  <= dv_s[i];
				ctx_s[i+1] <= ctx_s[i];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign quotient = dq_s[N];
	assign out_ctx  = ctx_s[N];

endmodule
